@@ rtl/core/isms_pkg.sv @@
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types and constants for the interval set merge/subtract block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package isms_pkg;
	localparam int ENTRIES_DEF    = 16;
	localparam int COORD_BITS_DEF = 20;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;
endpackage
`default_nettype wire

@@ rtl/core/isms_ram.sv @@
// ----------------------------------------------------------------------------
// isms_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module isms_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/interval_set_merge_subtract_top.sv @@
// Request to result: a read looks up one entry, an unused command just answers;
// an add merges each touching entry in (dropping it, shifting later ones down and
// rescanning from entry zero), then appends unless full; a remove counts pieces,
// is rejected if over capacity, else writes them to scratch and copies them back.
// Throughput: one request at a time; s_tready returns the cycle after the result
// handshake. Reset: arst_n clears the count and control; table contents undefined.
// ----------------------------------------------------------------------------
// interval_set_merge_subtract_top
// Interval table (entries not kept sorted) with merge-on-add, cut-on-remove and indexed read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module interval_set_merge_subtract_top #(
	parameter int ENTRIES    = isms_pkg::ENTRIES_DEF,
	parameter int COORD_BITS = isms_pkg::COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// cmd[1:0], span_start[21:2], span_end[41:22], entry_index[45:42]
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0], entry_count[6:2], read_start[26:7], read_end[46:27]
	output logic [47:0]      m_tdata
);
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = AW + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHK, S_DROP_RD, S_DROP_WR, S_APPEND,
		S_CNT_RD, S_CNT_CHK, S_REM_RD, S_REM_CHK, S_REM_WR2, S_COPY_RD,
		S_COPY_WR, S_READ_RD, S_READ_OUT, S_OUT
	} state_t;

	state_t state_q;
	logic [COORD_BITS-1:0] a_q, b_q;
	logic [3:0]            idx_q;
	logic [CW-1:0]         occ_q;
	logic [CW-1:0]         k_q;   // table scan position
	logic [CW:0]           n_q;   // remove result count
	logic                  merged_q;
	logic [1:0]            status_q;
	logic [19:0]           rs_q, re_q;
	logic                  pass_q; // remove second pass (count check done)

	logic [COORD_BITS-1:0] in_s, in_e, in_a, in_b;
	assign in_s = COORD_BITS'(s_tdata[21:2]);
	assign in_e = COORD_BITS'(s_tdata[41:22]);
	assign in_a = (in_s > in_e) ? in_e : in_s;
	assign in_b = (in_s > in_e) ? in_s : in_e;

	// main table and scratch table (2*ENTRIES) for remove
	logic              t_we;
	logic [AW-1:0]     t_wa, t_ra;
	logic [COORD_BITS-1:0] t_wlo, t_whi, t_rlo, t_rhi;
	logic              x_we;
	logic [SW-2:0]     x_wa, x_ra;
	logic [COORD_BITS-1:0] x_wlo, x_whi, x_rlo, x_rhi;

	isms_ram #(.WIDTH(COORD_BITS), .DEPTH(ENTRIES)) u_tlo (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wlo), .raddr(t_ra), .rdata(t_rlo));
	isms_ram #(.WIDTH(COORD_BITS), .DEPTH(ENTRIES)) u_thi (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_whi), .raddr(t_ra), .rdata(t_rhi));
	isms_ram #(.WIDTH(COORD_BITS), .DEPTH(2*ENTRIES)) u_xlo (
		.clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wlo), .raddr(x_ra), .rdata(x_rlo));
	isms_ram #(.WIDTH(COORD_BITS), .DEPTH(2*ENTRIES)) u_xhi (
		.clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_whi), .raddr(x_ra), .rdata(x_rhi));

	// shared compare unit over entry (s,e) vs (a,b)
	logic ov, adj, cov, outside, e_le_b, s_ge_a;
	assign ov      = (t_rlo <= b_q) && (a_q <= t_rhi);
	assign adj     = ((t_rhi != '1) && (t_rhi + 1'b1 == a_q)) ||
	                 ((b_q != '1) && (b_q + 1'b1 == t_rlo));
	assign cov     = (a_q <= t_rlo) && (t_rhi <= b_q);
	assign outside = (t_rlo > b_q) || (a_q > t_rhi);
	assign e_le_b  = t_rhi <= b_q;
	assign s_ge_a  = t_rlo >= a_q;

	logic [AW-1:0] k_a;
	assign k_a = k_q[AW-1:0];

	always_comb begin
		t_we = 1'b0; t_wa = k_a; t_wlo = x_rlo; t_whi = x_rhi; t_ra = k_a;
		x_we = 1'b0; x_wa = n_q[SW-2:0]; x_wlo = t_rlo; x_whi = t_rhi;
		x_ra = (SW-1)'(k_q);
		case (state_q)
			S_DROP_RD: t_ra = AW'(k_q + 1'b1);
			S_DROP_WR: begin
				t_we = 1'b1; t_wlo = t_rlo; t_whi = t_rhi;
			end
			S_APPEND: begin
				t_we = 1'b1; t_wa = occ_q[AW-1:0]; t_wlo = a_q; t_whi = b_q;
			end
			S_READ_RD: t_ra = idx_q[AW-1:0];
			S_REM_CHK: begin
				if (pass_q && !cov) begin
					x_we = 1'b1;
					if (outside) begin
						x_wlo = t_rlo; x_whi = t_rhi;
					end else if (e_le_b) begin
						x_wlo = t_rlo; x_whi = a_q - 1'b1;
					end else begin
						x_wlo = b_q + 1'b1; x_whi = t_rhi;
					end
				end
			end
			S_REM_WR2: begin
				// count already includes both pieces; lower piece goes second
				x_we = 1'b1; x_wa = (SW-1)'(n_q - 1'b1);
				x_wlo = t_rlo; x_whi = a_q - 1'b1;
			end
			S_COPY_WR: begin
				t_we = 1'b1;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			m_tvalid <= 1'b0;
			k_q <= '0; n_q <= '0; merged_q <= 1'b0; pass_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						a_q <= in_a; b_q <= in_b;
						idx_q <= s_tdata[45:42];
						status_q <= isms_pkg::ST_OK; rs_q <= '0; re_q <= '0;
						k_q <= '0; n_q <= '0; merged_q <= 1'b0; pass_q <= 1'b0;
						case (s_tdata[1:0])
							isms_pkg::CMD_ADD:    state_q <= S_RD;
							isms_pkg::CMD_REMOVE: state_q <= S_REM_RD;
							isms_pkg::CMD_READ:   state_q <= S_READ_RD;
							default:              state_q <= S_OUT;
						endcase
					end
				end
				S_RD: begin
					if (k_q >= occ_q) begin
						if (!merged_q && occ_q >= CW'(ENTRIES)) begin
							status_q <= isms_pkg::ST_FULL; state_q <= S_OUT;
						end else begin
							state_q <= S_APPEND;
						end
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (ov || adj) begin
						if (t_rlo < a_q) a_q <= t_rlo;
						if (t_rhi > b_q) b_q <= t_rhi;
						merged_q <= 1'b1;
						state_q <= S_DROP_RD;
					end else begin
						k_q <= k_q + 1'b1; state_q <= S_RD;
					end
				end
				S_DROP_RD: begin
					if (k_q + 1'b1 >= occ_q) begin
						occ_q <= occ_q - 1'b1; k_q <= '0; state_q <= S_RD;
					end else begin
						state_q <= S_DROP_WR;
					end
				end
				S_DROP_WR: begin
					k_q <= k_q + 1'b1; state_q <= S_DROP_RD;
				end
				S_APPEND: begin
					occ_q <= occ_q + 1'b1; state_q <= S_OUT;
				end
				S_REM_RD: begin
					if (k_q >= occ_q) begin
						if (!pass_q) begin
							if (n_q > (CW+1)'(ENTRIES)) begin
								status_q <= isms_pkg::ST_FULL; state_q <= S_OUT;
							end else begin
								pass_q <= 1'b1; k_q <= '0; n_q <= '0;
							end
						end else begin
							k_q <= '0; state_q <= (n_q == '0) ? S_COPY_WR : S_COPY_RD;
						end
					end else begin
						state_q <= S_REM_CHK;
					end
				end
				S_REM_CHK: begin
					if (!cov && !outside && !e_le_b && !s_ge_a) begin
						n_q <= n_q + 2'd2;
						if (pass_q) begin
							state_q <= S_REM_WR2;
						end else begin
							k_q <= k_q + 1'b1; state_q <= S_REM_RD;
						end
					end else begin
						if (!cov) n_q <= n_q + 1'b1;
						k_q <= k_q + 1'b1; state_q <= S_REM_RD;
					end
				end
				S_REM_WR2: begin
					k_q <= k_q + 1'b1; state_q <= S_REM_RD;
				end
				S_COPY_RD: state_q <= S_COPY_WR;
				S_COPY_WR: begin
					if (k_q + 1'b1 >= CW'(n_q)) begin
						occ_q <= CW'(n_q); state_q <= S_OUT;
					end else begin
						k_q <= k_q + 1'b1; state_q <= S_COPY_RD;
					end
				end
				S_READ_RD: begin
					state_q <= S_READ_OUT;
				end
				S_READ_OUT: begin
					if ({1'b0, idx_q} < 5'(occ_q) && {1'b0, idx_q} < 5'(ENTRIES)) begin
						rs_q <= 20'(t_rlo); re_q <= 20'(t_rhi);
					end else begin
						status_q <= isms_pkg::ST_RANGE;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, re_q, rs_q, 5'(occ_q), status_q};
					end else if (m_tready) begin
						m_tvalid <= 1'b0; state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
			(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
	endproperty
	assert property (p_out_hold) else $error("stalled result dropped or changed");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) occ_q <= CW'(ENTRIES);
	endproperty
	assert property (p_count_bound) else $error("count above capacity");

	property p_no_ready_busy;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready;
	endproperty
	assert property (p_no_ready_busy) else $error("ready while result pending");

	property p_full_keeps_count;
		@(posedge clk) disable iff (!arst_n)
			(m_tvalid && m_tdata[1:0] == isms_pkg::ST_FULL) |-> $stable(occ_q);
	endproperty
	assert property (p_full_keeps_count) else $error("rejected request changed count");
endmodule
`default_nettype wire

@@ tb/tb_interval_set_merge_subtract_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_set_merge_subtract_top
// Drives add, remove and read requests into the interval table with random
// gaps on both stream sides and checks every response against a local model
// of the table kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_interval_set_merge_subtract_top;
	localparam int NENT = 16;

	typedef struct packed {
		logic [3:0]     entry_index;
		logic [19:0]    span_end;
		logic [19:0]    span_start;
		isms_pkg::cmd_t cmd;
	} req_t;

	typedef struct packed {
		logic [19:0]       read_end;
		logic [19:0]       read_start;
		logic [4:0]        entry_count;
		isms_pkg::status_t status;
	} rsp_t;

	class interval_scoreboard;
		logic [19:0] lo [NENT];
		logic [19:0] hi [NENT];
		int count;
		rsp_t pending [$];
		int errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void unlink(int k);
			for (int j = k; j + 1 < count; j++) begin
				lo[j] = lo[j + 1];
				hi[j] = hi[j + 1];
			end
			count--;
		endfunction

		function bit touches(logic [20:0] s, logic [20:0] e, logic [20:0] a, logic [20:0] b);
			return (s <= b && a <= e) || (e + 1 == a) || (b + 1 == s);
		endfunction

		function isms_pkg::status_t merge_in(logic [19:0] a, logic [19:0] b);
			int k;
			bit merged;
			k = 0;
			merged = 0;
			while (k < count) begin
				if (touches(lo[k], hi[k], a, b)) begin
					if (lo[k] < a) a = lo[k];
					if (hi[k] > b) b = hi[k];
					unlink(k);
					merged = 1;
					k = 0;
				end else begin
					k++;
				end
			end
			if (!merged && count >= NENT) return isms_pkg::ST_FULL;
			lo[count] = a;
			hi[count] = b;
			count++;
			return isms_pkg::ST_OK;
		endfunction

		function isms_pkg::status_t cut_out(logic [19:0] a, logic [19:0] b);
			logic [19:0] nlo [2*NENT];
			logic [19:0] nhi [2*NENT];
			int n;
			n = 0;
			for (int k = 0; k < count; k++) begin
				if (a <= lo[k] && hi[k] <= b) begin
				end else if (lo[k] > b || a > hi[k]) begin
					nlo[n] = lo[k]; nhi[n] = hi[k]; n++;
				end else if (hi[k] <= b) begin
					nlo[n] = lo[k]; nhi[n] = a - 20'd1; n++;
				end else if (lo[k] >= a) begin
					nlo[n] = b + 20'd1; nhi[n] = hi[k]; n++;
				end else begin
					nlo[n] = b + 20'd1; nhi[n] = hi[k]; n++;
					nlo[n] = lo[k]; nhi[n] = a - 20'd1; n++;
				end
			end
			if (n > NENT) return isms_pkg::ST_FULL;
			for (int k = 0; k < n; k++) begin
				lo[k] = nlo[k];
				hi[k] = nhi[k];
			end
			count = n;
			return isms_pkg::ST_OK;
		endfunction

		function void note_request(req_t r);
			rsp_t x;
			logic [19:0] a, b;
			a = r.span_start;
			b = r.span_end;
			if (a > b) begin
				a = r.span_end;
				b = r.span_start;
			end
			x = '0;
			x.status = isms_pkg::ST_OK;
			case (r.cmd)
				isms_pkg::CMD_ADD: x.status = merge_in(a, b);
				isms_pkg::CMD_REMOVE: x.status = cut_out(a, b);
				isms_pkg::CMD_READ: begin
					if (r.entry_index < count) begin
						x.read_start = lo[r.entry_index];
						x.read_end = hi[r.entry_index];
					end else begin
						x.status = isms_pkg::ST_RANGE;
					end
				end
				default: ;
			endcase
			x.entry_count = 5'(count);
			pending.push_back(x);
		endfunction

		function void check_response(logic [47:0] d);
			rsp_t got, want;
			got = rsp_t'(d[46:0]);
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", d);
				return;
			end
			want = pending.pop_front();
			if (d[47] !== 1'b0 || got.status !== want.status
					|| got.entry_count !== want.entry_count
					|| got.read_start !== want.read_start || got.read_end !== want.read_end) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp st=%0d n=%0d %h..%h got st=%0d n=%0d %h..%h",
						want.status, want.entry_count, want.read_start, want.read_end,
						got.status, got.entry_count, got.read_start, got.read_end);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;

	interval_scoreboard table_model = new();

	interval_set_merge_subtract_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// called at a rising edge; returns at the edge that accepts the request
	task automatic send_request(isms_pkg::cmd_t c, logic [19:0] a, logic [19:0] b,
			logic [3:0] idx);
		req_t r;
		int gap;
		r.cmd = c;
		r.span_start = a;
		r.span_end = b;
		r.entry_index = idx;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {2'b00, r};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		table_model.note_request(r);
	endtask

	function automatic logic [19:0] rand_coord(int mode);
		case (mode)
			0: return 20'($urandom_range(0, 63));
			1: return 20'hFFFFF - 20'($urandom_range(0, 63));
			default: return 20'($urandom);
		endcase
	endfunction

	initial begin : rsp_side
		int w;
		logic [47:0] d;
		@(posedge clk);
		forever begin
			w = $urandom_range(0, 3);
			if (w != 0) begin
				m_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1;
			@(negedge clk);
			while (!m_tvalid) @(negedge clk);
			d = m_tdata;
			@(posedge clk);
			table_model.check_response(d);
		end
	end

	initial begin
		int mode;
		logic [19:0] a, w;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: edges, reversed spans, adjacency at the coordinate limits
		send_request(isms_pkg::CMD_READ, 0, 0, 0);
		send_request(isms_pkg::CMD_ADD, 20'hFFFFF, 20'hFFFFF, 0);
		send_request(isms_pkg::CMD_ADD, 0, 0, 0);
		send_request(isms_pkg::CMD_READ, 0, 0, 1);
		send_request(isms_pkg::CMD_ADD, 20'hFFFFE, 5, 0);
		send_request(isms_pkg::CMD_READ, 0, 0, 0);
		send_request(isms_pkg::CMD_REMOVE, 100, 50, 0);
		send_request(isms_pkg::CMD_READ, 0, 0, 0);
		send_request(isms_pkg::CMD_READ, 0, 0, 1);
		send_request(isms_pkg::CMD_REMOVE, 0, 20'hFFFFF, 0);
		send_request(isms_pkg::CMD_NOP, 20'hFFFFF, 20'hFFFFF, 4'hF);
		for (int i = 0; i < 16; i++)
			send_request(isms_pkg::CMD_ADD, 20'(i * 4), 20'(i * 4 + 1), 0);
		send_request(isms_pkg::CMD_ADD, 1000, 1000, 0);
		send_request(isms_pkg::CMD_REMOVE, 1, 1, 0);
		send_request(isms_pkg::CMD_READ, 0, 0, 4'hF);
		send_request(isms_pkg::CMD_ADD, 2, 2, 0);
		send_request(isms_pkg::CMD_REMOVE, 0, 20'hFFFFF, 0);
		for (int i = 0; i < 1200; i++) begin
			mode = $urandom_range(0, 2);
			if (i % 150 == 0) send_request(isms_pkg::CMD_REMOVE, 0, 20'hFFFFF, 0);
			a = rand_coord(mode);
			w = (mode == 2 && $urandom_range(0, 3) == 0) ? 20'($urandom)
				: 20'($urandom_range(0, 12));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_request(isms_pkg::CMD_ADD, a, a + w, 0);
				4, 5: send_request(isms_pkg::CMD_REMOVE, a + w, a, 0);
				6, 7, 8: send_request(isms_pkg::CMD_READ, 20'($urandom), 20'($urandom),
					4'($urandom));
				default: send_request(isms_pkg::cmd_t'($urandom_range(0, 3)), 20'($urandom),
					20'($urandom), 4'($urandom));
			endcase
		end
		s_tvalid <= 0;
		while (table_model.pending.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		if (table_model.errors == 0 && table_model.pending.size() == 0) begin
			$display("PASS interval_set_merge_subtract_top");
		end else begin
			$display("FAIL interval_set_merge_subtract_top");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL interval_set_merge_subtract_top");
		$finish;
	end
endmodule
